### rtl/core/wlr_pkg.sv
// Shared types, constants and helpers for the 5/3 lifting row core.
package wlr_pkg;

  localparam int SampleW = 17;
  localparam int ValueW  = 19;
  localparam int StateW  = 20;
  // Working width of the lifting arithmetic; no intermediate can exceed it.
  localparam int AccW    = 22;
  localparam int MaxRes  = 3;

  localparam logic BandLow  = 1'b0;
  localparam logic BandHigh = 1'b1;

  typedef enum logic {
    DirForward = 1'b0,
    DirInverse = 1'b1
  } dir_e;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     band;
    logic                     row_done;
  } result_t;

  // Results produced by one input beat, in delivery order from index 0.
  typedef struct packed {
    logic [1:0]                num;
    result_t [MaxRes-1:0]      res;
  } lift_out_t;

  function automatic result_t mk_result(logic signed [AccW-1:0] v, logic band);
    result_t r;
    r.value    = v[ValueW-1:0];
    r.band     = band;
    r.row_done = 1'b0;
    return r;
  endfunction

endpackage

### rtl/core/wlr_lift.sv
// Lifting datapath and row state: turns one registered beat into up to three results.
module wlr_lift
  import wlr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_dir_i,
  input  logic                      commit_i,
  input  logic signed [SampleW-1:0] x_i,
  input  logic                      last_i,
  output lift_out_t                 lift_o
);

  localparam logic signed [AccW-1:0] Two = AccW'(2);

  dir_e                     dir_q;
  logic signed [StateW-1:0] even_q, even_d;
  logic signed [StateW-1:0] odd_q, odd_d;
  logic signed [StateW-1:0] pd_q, pd_d;
  logic signed [StateW-1:0] pe_q, pe_d;
  logic                     parity_q, parity_d;
  logic                     first_q, first_d;
  logic                     held_q, held_d;

  logic signed [AccW-1:0]   xw, ev, od, pd, pe, d, dp, s, xe, xo;
  logic [1:0]               n;
  logic                     restart;

  always_comb begin
    even_d   = even_q;
    odd_d    = odd_q;
    pd_d     = pd_q;
    pe_d     = pe_q;
    parity_d = parity_q;
    first_d  = first_q;
    held_d   = held_q;
    lift_o   = '0;
    n        = '0;
    restart  = 1'b0;
    xw = AccW'(x_i);
    ev = AccW'(even_q);
    od = AccW'(odd_q);
    pd = AccW'(pd_q);
    pe = AccW'(pe_q);
    d  = '0;
    dp = '0;
    s  = '0;
    xe = '0;
    xo = '0;
    if (dir_q == DirForward) begin
      if (!parity_q) begin
        // An even sample closes the pending pair as its right neighbor.
        if (held_q) begin
          d  = od - ((ev + xw) >>> 1);
          dp = first_q ? d : pd;
          s  = ev + ((dp + d + Two) >>> 2);
          lift_o.res[n] = mk_result(s, BandLow);
          n = n + 2'd1;
          lift_o.res[n] = mk_result(d, BandHigh);
          n = n + 2'd1;
          pd_d    = d[StateW-1:0];
          first_d = 1'b0;
        end
        even_d = StateW'(x_i);
        held_d = 1'b0;
        if (last_i) begin
          if (first_d) begin
            s = xw;
          end else begin
            s = xw + (((AccW'(pd_d) <<< 1) + Two) >>> 2);
          end
          lift_o.res[n] = mk_result(s, BandLow);
          n = n + 2'd1;
          restart = 1'b1;
        end else begin
          parity_d = 1'b1;
        end
      end else begin
        odd_d  = StateW'(x_i);
        held_d = 1'b1;
        if (last_i) begin
          // Mirrored right neighbor equals the held even sample.
          d  = xw - ev;
          dp = first_q ? d : pd;
          s  = ev + ((dp + d + Two) >>> 2);
          lift_o.res[n] = mk_result(s, BandLow);
          n = n + 2'd1;
          lift_o.res[n] = mk_result(d, BandHigh);
          n = n + 2'd1;
          restart = 1'b1;
        end else begin
          parity_d = 1'b0;
        end
      end
    end else begin
      if (!parity_q) begin
        even_d = StateW'(x_i);
        if (last_i) begin
          if (first_q) begin
            lift_o.res[n] = mk_result(xw, BandLow);
            n = n + 2'd1;
          end else begin
            xe = xw - (((pd <<< 1) + Two) >>> 2);
            xo = pd + ((pe + xe) >>> 1);
            lift_o.res[n] = mk_result(xo, BandHigh);
            n = n + 2'd1;
            lift_o.res[n] = mk_result(xe, BandLow);
            n = n + 2'd1;
          end
          restart = 1'b1;
        end else begin
          parity_d = 1'b1;
        end
      end else begin
        dp = first_q ? xw : pd;
        xe = ev - ((dp + xw + Two) >>> 2);
        if (!first_q) begin
          xo = pd + ((pe + xe) >>> 1);
          lift_o.res[n] = mk_result(xo, BandHigh);
          n = n + 2'd1;
        end
        lift_o.res[n] = mk_result(xe, BandLow);
        n = n + 2'd1;
        pe_d    = xe[StateW-1:0];
        pd_d    = StateW'(x_i);
        first_d = 1'b0;
        if (last_i) begin
          // The final odd sample mirrors its right even neighbor.
          lift_o.res[n] = mk_result(xw + xe, BandHigh);
          n = n + 2'd1;
          restart = 1'b1;
        end else begin
          parity_d = 1'b0;
        end
      end
    end
    if (last_i && (n != 2'd0)) begin
      lift_o.res[n - 2'd1].row_done = 1'b1;
    end
    lift_o.num = n;
    if (restart) begin
      even_d   = '0;
      odd_d    = '0;
      pd_d     = '0;
      pe_d     = '0;
      parity_d = 1'b0;
      first_d  = 1'b1;
      held_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= DirForward;
      even_q   <= '0;
      odd_q    <= '0;
      pd_q     <= '0;
      pe_q     <= '0;
      parity_q <= 1'b0;
      first_q  <= 1'b1;
      held_q   <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q    <= dir_e'(cfg_dir_i);
      even_q   <= '0;
      odd_q    <= '0;
      pd_q     <= '0;
      pe_q     <= '0;
      parity_q <= 1'b0;
      first_q  <= 1'b1;
      held_q   <= 1'b0;
    end else if (commit_i) begin
      even_q   <= even_d;
      odd_q    <= odd_d;
      pd_q     <= pd_d;
      pe_q     <= pe_d;
      parity_q <= parity_d;
      first_q  <= first_d;
      held_q   <= held_d;
    end
  end

`ifndef SYNTHESIS
  a_row_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && last_i |=> !parity_q && first_q && !held_q)
    else $error("row state not restarted after the last beat of a row");

  a_fwd_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q == DirForward && !last_i |-> lift_o.num != 2'd3)
    else $error("forward beat inside a row produced three results");
`endif

endmodule

### rtl/core/wlr_res_fifo.sv
// Result queue: takes up to three results per cycle, delivers one beat per cycle while out_stall_i is low.
module wlr_res_fifo
  import wlr_pkg::*;
#(
  parameter int Depth = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_en_i,
  input  lift_out_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output result_t   out_res_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  result_t [Depth-1:0] mem_q;
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     push_num;
  logic                pop;

  assign push_num    = push_en_i ? CntW'(push_i.num) : '0;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_res_o   = mem_q[rd_ptr_q];
  assign room_o      = (count_q <= CntW'(Depth - MaxRes));
  assign count_d     = count_q + push_num - CntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (push_en_i && (k < int'(push_i.num))) begin
        mem_q[wr_ptr_q + PtrW'(k)] <= push_i.res[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_num[PtrW-1:0];
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");
`endif

endmodule

### rtl/core/wavelet53_lifting_row_core.sv
// Top level of the streaming LeGall 5/3 lifting row core.
// Forward mode (direction 0) takes pixels and emits interleaved low/high
// coefficients; inverse mode (direction 1) takes interleaved coefficients and
// emits samples. Rows have any length of at least 1, the last element is
// flagged by row_end_i, and symmetric extension is applied at both row ends.
// A beat enters an input register, is lifted combinationally and its zero to
// three results are written to a result queue of ResDepth entries at once.
// The input side takes one beat per cycle while the queue has room for
// three results; the output side delivers one result per cycle while
// out_stall_i is low, so the sustained rate is one input beat per cycle,
// bounded by the single result port (about one result per beat on average,
// up to three at a row end). Writing the direction register restarts the row.
// ResDepth must be a power of two, 4 or more.
module wavelet53_lifting_row_core
  import wlr_pkg::*;
#(
  parameter int ResDepth = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_in_i,
  input  logic                      row_end_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ValueW-1:0]  value_out_o,
  output logic                      band_o,
  output logic                      row_done_o
);

  logic                      in_valid_q;
  logic signed [SampleW-1:0] x_q;
  logic                      last_q;
  logic                      room;
  logic                      commit;
  lift_out_t                 lift;
  result_t                   out_res;

  assign commit     = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      x_q    <= sample_in_i;
      last_q <= row_end_i;
    end
  end

  wlr_lift u_lift (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_dir_i (cfg_wdata_i),
    .commit_i  (commit),
    .x_i       (x_q),
    .last_i    (last_q),
    .lift_o    (lift)
  );

  wlr_res_fifo #(
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (commit),
    .push_i      (lift),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign value_out_o = out_res.value;
  assign band_o      = out_res.band;
  assign row_done_o  = out_res.row_done;

`ifndef SYNTHESIS
  a_stall_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with an empty input register");

  a_held_beat_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !commit |=> in_valid_q && $stable(x_q) && $stable(last_q))
    else $error("pending beat lost before it was lifted");
`endif

endmodule

### sim/tb_wavelet53_lifting_row_core.sv
// Self-checking testbench for the streaming 5/3 lifting row core in both directions.
`timescale 1ns / 1ps

module tb_wavelet53_lifting_row_core;
  import wlr_pkg::*;

  localparam int SettleCycles  = 6;
  localparam int WatchdogLimit = 2000;
  localparam logic signed [SampleW-1:0] MaxSample = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] MinSample = {1'b1, {(SampleW-1){1'b0}}};

  logic                      clk_i     = 1'b0;
  logic                      rst_ni    = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic                      cfg_wdata = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic signed [SampleW-1:0] sample    = '0;
  logic                      row_end   = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [ValueW-1:0]  value_out;
  logic                      band;
  logic                      row_done;

  // Lifting state kept by the testbench, mirrors the row position of the core.
  dir_e dir_mode = DirForward;
  int   held_even, held_odd, prev_detail, prev_even_out;
  bit   parity, first_pair = 1'b1, pair_held;

  result_t lifted_due[$];
  int      error_count = 0;
  int      beats_sent  = 0;
  int      stall_left  = 0;
  int      quiet_cycles = 0;
  bit      gaps_on = 1'b1;

  wavelet53_lifting_row_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_in_i (sample),
    .row_end_i   (row_end),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .value_out_o (value_out),
    .band_o      (band),
    .row_done_o  (row_done)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void restart_row();
    held_even     = 0;
    held_odd      = 0;
    prev_detail   = 0;
    prev_even_out = 0;
    parity        = 1'b0;
    first_pair    = 1'b1;
    pair_held     = 1'b0;
  endfunction

  function automatic void push_lifted(input int v, input logic b);
    result_t r;
    r.value    = v[ValueW-1:0];
    r.band     = b;
    r.row_done = 1'b0;
    lifted_due.push_back(r);
  endfunction

  // Works out the results one accepted beat causes and queues them.
  function automatic void predict_lift(input logic signed [SampleW-1:0] smp, input logic last);
    int      v, d, dp, s, xe, xo, n;
    result_t tail;
    v = int'(smp);
    n = 0;
    if (dir_mode == DirForward) begin
      if (!parity) begin
        if (pair_held) begin
          d  = held_odd - ((held_even + v) >>> 1);
          dp = first_pair ? d : prev_detail;
          s  = held_even + ((dp + d + 2) >>> 2);
          push_lifted(s, BandLow);
          push_lifted(d, BandHigh);
          n += 2;
          prev_detail = d;
          first_pair  = 1'b0;
        end
        held_even = v;
        pair_held = 1'b0;
        if (last) begin
          s = first_pair ? v : v + ((2 * prev_detail + 2) >>> 2);
          push_lifted(s, BandLow);
          n++;
          restart_row();
        end else begin
          parity = 1'b1;
        end
      end else begin
        held_odd  = v;
        pair_held = 1'b1;
        if (last) begin
          // Symmetric extension: the right neighbour of the last odd sample is its left one.
          d  = v - held_even;
          dp = first_pair ? d : prev_detail;
          s  = held_even + ((dp + d + 2) >>> 2);
          push_lifted(s, BandLow);
          push_lifted(d, BandHigh);
          n += 2;
          restart_row();
        end else begin
          parity = 1'b0;
        end
      end
    end else begin
      if (!parity) begin
        held_even = v;
        if (last) begin
          if (first_pair) begin
            push_lifted(v, BandLow);
            n++;
          end else begin
            xe = v - ((2 * prev_detail + 2) >>> 2);
            xo = prev_detail + ((prev_even_out + xe) >>> 1);
            push_lifted(xo, BandHigh);
            push_lifted(xe, BandLow);
            n += 2;
          end
          restart_row();
        end else begin
          parity = 1'b1;
        end
      end else begin
        dp = first_pair ? v : prev_detail;
        xe = held_even - ((dp + v + 2) >>> 2);
        if (!first_pair) begin
          xo = prev_detail + ((prev_even_out + xe) >>> 1);
          push_lifted(xo, BandHigh);
          n++;
        end
        push_lifted(xe, BandLow);
        n++;
        prev_even_out = xe;
        prev_detail   = v;
        first_pair    = 1'b0;
        if (last) begin
          push_lifted(v + xe, BandHigh);
          n++;
          restart_row();
        end else begin
          parity = 1'b0;
        end
      end
    end
    if (last && n > 0) begin
      tail = lifted_due.pop_back();
      tail.row_done = 1'b1;
      lifted_due.push_back(tail);
    end
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample();
    logic [SampleW-1:0] raw;
    raw = SampleW'($urandom_range(0, (1 << SampleW) - 1));
    case ($urandom_range(0, 9))
      0:       return MinSample;
      1:       return MaxSample;
      2, 3:    return SampleW'($urandom_range(0, 63) - 32);
      default: return raw;
    endcase
  endfunction

  task automatic send_beat(input logic signed [SampleW-1:0] smp, input logic last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sample   <= smp;
    row_end  <= last;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    predict_lift(smp, last);
    beats_sent++;
  endtask

  // Holds the input side until every queued result has been delivered, then
  // gives beats that cause no result time to leave the pipeline.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (lifted_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_direction(input dir_e dir);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= dir;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    dir_mode = dir;
    restart_row();
  endtask

  task automatic test_forward_edges();
    write_direction(DirForward);
    send_beat(MaxSample, 1'b0);
    send_beat(MinSample, 1'b1);
    send_beat(MinSample, 1'b0);
    send_beat(MaxSample, 1'b0);
    send_beat(MinSample, 1'b0);
    send_beat(MaxSample, 1'b1);
    // A one-element row and a three-element row end on an even position.
    send_beat(MaxSample, 1'b1);
    send_beat(17'sd5, 1'b0);
    send_beat(-17'sd7, 1'b0);
    send_beat(MinSample, 1'b1);
  endtask

  task automatic test_inverse_edges();
    write_direction(DirInverse);
    send_beat(MinSample, 1'b0);
    send_beat(MaxSample, 1'b1);
    send_beat(MaxSample, 1'b0);
    send_beat(MinSample, 1'b0);
    send_beat(MaxSample, 1'b0);
    send_beat(MinSample, 1'b1);
    send_beat(MinSample, 1'b1);
    send_beat(-17'sd3, 1'b0);
    send_beat(MaxSample, 1'b0);
    send_beat(MaxSample, 1'b1);
  endtask

  task automatic test_restart_mid_row();
    write_direction(DirForward);
    send_beat(17'sd100, 1'b0);
    send_beat(-17'sd200, 1'b0);
    send_beat(17'sd300, 1'b0);
    // The write must drop the unfinished row without emitting anything.
    write_direction(DirInverse);
    send_beat(17'sd40, 1'b0);
    send_beat(-17'sd41, 1'b1);
  endtask

  task automatic test_random_rows(input int budget);
    int   stop_at, len, k, phase;
    dir_e dir;
    stop_at = beats_sent + budget;
    phase   = 0;
    while (beats_sent < stop_at) begin
      dir = (phase % 2 == 0) ? DirForward : DirInverse;
      phase++;
      write_direction(dir);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 5)) begin
        len = ($urandom_range(0, 9) == 0) ? 2 * $urandom_range(0, 4) + 1
                                          : 2 * $urandom_range(1, 8);
        for (k = 0; k < len; k++) send_beat(pick_sample(), k == len - 1);
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
      // Sometimes leave a row open so that the next write has to discard it.
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 5)) send_beat(pick_sample(), 1'b0);
    end
  endtask

  // Compares each delivered beat with the oldest queued result, then draws
  // the stall that follows it.
  always @(posedge clk_i) begin : check_lifted
    result_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (lifted_due.size() == 0) begin
          $display("%0t: unexpected result value %0d band %0b row_done %0b",
                   $time, value_out, band, row_done);
          error_count++;
        end else begin
          want = lifted_due.pop_front();
          if (value_out !== want.value) begin
            $display("%0t: value mismatch expected %0d actual %0d", $time, want.value,
                     value_out);
            error_count++;
          end
          if (band !== want.band) begin
            $display("%0t: band mismatch expected %0b actual %0b", $time, want.band, band);
            error_count++;
          end
          if (row_done !== want.row_done) begin
            $display("%0t: row_done mismatch expected %0b actual %0b", $time,
                     want.row_done, row_done);
            error_count++;
          end
        end
        stall_left = gaps_on ? $urandom_range(0, 9) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    restart_row();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_forward_edges();
    test_inverse_edges();
    test_restart_mid_row();
    test_random_rows(230);
    wait_drained();
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
